// ===== rtl/core/euler_to_quaternion_macros.svh =====
// Assertion macros shared by the euler_to_quaternion RTL.
`ifndef EULER_TO_QUATERNION_MACROS_SVH
`define EULER_TO_QUATERNION_MACROS_SVH

// Assert that a property holds at every rising clock edge outside reset.
`define E2Q_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assert that a signal never carries unknown bits outside reset.
`define E2Q_ASSERT_KNOWN(label, sig, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !$isunknown(sig)) \
    else $error(msg);

`endif

// ===== rtl/core/e2q_pkg.sv =====
// Package with the constants and types shared by the euler_to_quaternion RTL.
package e2q_pkg;

  // Fractional bits of the internal datapath.
  localparam int unsigned CoreFrac = 30;

  // Number of entries in the arctangent table.
  localparam int unsigned AtanEntries = 30;

  // Width of the internal datapath values.
  localparam int unsigned CoreW = 36;

  // CORDIC gain constant on 30 fractional bits.
  localparam logic signed [CoreW-1:0] GainQ30 = 36'sd652032874;

  // Arctangent of 2^-i, one unit is 2*pi/2^32.
  function automatic logic signed [CoreW-1:0] atan_turn(input int unsigned idx);
    logic signed [CoreW-1:0] v;
    v = '0;
    case (idx)
      0: v = 36'sd536870912;
      1: v = 36'sd316933406;
      2: v = 36'sd167458907;
      3: v = 36'sd85004756;
      4: v = 36'sd42667331;
      5: v = 36'sd21354465;
      6: v = 36'sd10679838;
      7: v = 36'sd5340245;
      8: v = 36'sd2670163;
      9: v = 36'sd1335087;
      10: v = 36'sd667544;
      11: v = 36'sd333772;
      12: v = 36'sd166886;
      13: v = 36'sd83443;
      14: v = 36'sd41722;
      15: v = 36'sd20861;
      16: v = 36'sd10430;
      17: v = 36'sd5215;
      18: v = 36'sd2608;
      19: v = 36'sd1304;
      20: v = 36'sd652;
      21: v = 36'sd326;
      22: v = 36'sd163;
      23: v = 36'sd81;
      24: v = 36'sd41;
      25: v = 36'sd20;
      26: v = 36'sd10;
      27: v = 36'sd5;
      28: v = 36'sd3;
      29: v = 36'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Rotator state for one angle.
  typedef struct packed {
    logic signed [CoreW-1:0] x;
    logic signed [CoreW-1:0] y;
    logic signed [CoreW-1:0] z;
  } rot_t;

endpackage

// ===== rtl/core/e2q_cordic_cell.sv =====
// One CORDIC rotation cell: rotates three angles by one fixed micro-angle.
module e2q_cordic_cell #(
  parameter int unsigned Stage = 0
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  e2q_pkg::rot_t   rot_i [3],
  output e2q_pkg::rot_t   rot_o [3]
);

  e2q_pkg::rot_t rot_d [3];
  e2q_pkg::rot_t rot_q [3];

  // Arithmetic shift is a floor shift on two's complement values.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!rot_i[k].z[e2q_pkg::CoreW-1]) begin
        rot_d[k].x = rot_i[k].x - (rot_i[k].y >>> Stage);
        rot_d[k].y = rot_i[k].y + (rot_i[k].x >>> Stage);
        rot_d[k].z = rot_i[k].z - (e2q_pkg::atan_turn(Stage) <<< 1);
      end else begin
        rot_d[k].x = rot_i[k].x + (rot_i[k].y >>> Stage);
        rot_d[k].y = rot_i[k].y - (rot_i[k].x >>> Stage);
        rot_d[k].z = rot_i[k].z + (e2q_pkg::atan_turn(Stage) <<< 1);
      end
    end
  end

  // Hand the state to the next cell when the pipeline advances.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q <= rot_d;
    end
  end

  assign rot_o = rot_q;

endmodule

// ===== rtl/core/e2q_sqrt_cell.sv =====
// One step of the digit-by-digit square root, two radicand bits per cell.
module e2q_sqrt_cell #(
  parameter int unsigned Step = 0,
  parameter int unsigned RadW = 64,
  parameter int unsigned PartW = 36,
  parameter int unsigned NPart = 4
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [RadW-1:0]         rem_i,
  input  logic [RadW-1:0]         root_i,
  input  logic signed [PartW-1:0] part_i [NPart],
  output logic [RadW-1:0]         rem_o,
  output logic [RadW-1:0]         root_o,
  output logic signed [PartW-1:0] part_o [NPart]
);

  localparam int unsigned BitPos = RadW - 2 - 2 * Step;

  logic [RadW-1:0] bit_w;
  logic [RadW-1:0] trial;
  logic [RadW-1:0] rem_d, root_d, rem_q, root_q;
  logic signed [PartW-1:0] part_q [NPart];

  // Compare the remainder with root plus the current bit.
  always_comb begin
    bit_w = '0;
    bit_w[BitPos] = 1'b1;
    trial = root_i + bit_w;
    if (rem_i >= trial) begin
      rem_d  = rem_i - trial;
      root_d = (root_i >> 1) + bit_w;
    end else begin
      rem_d  = rem_i;
      root_d = root_i >> 1;
    end
  end

  // Pass the result and the quaternion parts on to the next cell.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      part_q <= part_i;
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign part_o = part_q;

endmodule

// ===== rtl/core/e2q_div_cell.sv =====
// One step of the restoring divider, applied to four magnitudes at once.
module e2q_div_cell #(
  parameter int unsigned NumW = 48,
  parameter int unsigned DenW = 32
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [DenW-1:0] den_i,
  input  logic [NumW-1:0] num_i [4],
  input  logic [DenW:0]   rem_i [4],
  input  logic [NumW-1:0] quo_i [4],
  input  logic [3:0]      neg_i,
  output logic [DenW-1:0] den_o,
  output logic [NumW-1:0] num_o [4],
  output logic [DenW:0]   rem_o [4],
  output logic [NumW-1:0] quo_o [4],
  output logic [3:0]      neg_o
);

  logic [NumW-1:0] num_d [4];
  logic [DenW:0]   rem_d [4];
  logic [NumW-1:0] quo_d [4];
  logic [DenW+1:0] sh;

  // Shift in the next numerator bit and try a subtraction.
  always_comb begin
    sh = '0;
    for (int k = 0; k < 4; k++) begin
      sh = {rem_i[k], num_i[k][NumW-1]};
      num_d[k] = num_i[k] << 1;
      if (sh >= {2'b00, den_i}) begin
        rem_d[k] = (DenW+1)'(sh - {2'b00, den_i});
        quo_d[k] = {quo_i[k][NumW-2:0], 1'b1};
      end else begin
        rem_d[k] = (DenW+1)'(sh);
        quo_d[k] = {quo_i[k][NumW-2:0], 1'b0};
      end
    end
  end

  // Register the step result for the next cell.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_o <= den_i;
      num_o <= num_d;
      rem_o <= rem_d;
      quo_o <= quo_d;
      neg_o <= neg_i;
    end
  end

endmodule

// ===== rtl/core/euler_to_quaternion.sv =====
// Top level of the Euler-angles-to-quaternion converter.
// Converts roll, pitch and yaw binary angles into a normalized Z-Y-X attitude
// quaternion in Q2.FRAC_BITS. The design is one pipeline of cells: CORDIC_STAGES
// rotation cells (at most 30), two product stages, a squaring stage, a summing
// stage, a square-root cell per two radicand bits (32 cells), a divider setup
// stage and one divider cell per quotient bit (32 + FRAC_BITS cells), followed
// by the output register. It accepts one transaction per cycle while the
// output is not stalled; a stall on the output holds the whole pipeline.
module euler_to_quaternion #(
  parameter int unsigned ANGLE_BITS    = 16,
  parameter int unsigned FRAC_BITS     = 16,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // [ANGLE_BITS-1:0] roll_angle, then pitch_angle, then yaw_angle, zero fill
  input  logic [((3*ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // q_scalar, q_x, q_y, q_z from the lowest bits, FRAC_BITS+2 each, zero fill
  output logic [((4*(FRAC_BITS+2)+7)/8)*8-1:0] m_axis_tdata
);

  `include "euler_to_quaternion_macros.svh"

  localparam int unsigned CW     = e2q_pkg::CoreW;
  localparam int unsigned NStg   = (CORDIC_STAGES < e2q_pkg::AtanEntries) ?
                                   CORDIC_STAGES : e2q_pkg::AtanEntries;
  localparam int unsigned OutW   = FRAC_BITS + 2;
  localparam int unsigned RadW   = 64;
  localparam int unsigned NSqrt  = RadW / 2;
  localparam int unsigned DenW   = 33;
  localparam int unsigned NumW   = 32 + FRAC_BITS;
  localparam int unsigned OutDW  = ((4*OutW+7)/8)*8;
  localparam int unsigned Lat    = NStg + 3 + NSqrt + 1 + NumW + 1;

  // Product of two values that fit in 32 signed bits, shifted back to the core scale.
  function automatic logic signed [CW-1:0] mulq(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    logic signed [63:0] p;
    p = 64'($signed(a[31:0])) * 64'($signed(b[31:0]));
    return CW'(p >>> e2q_pkg::CoreFrac);
  endfunction

  // Pipeline advances when the output register is free or being drained.
  logic adv;
  logic [Lat-1:0] vld_q;
  logic out_vld_q;
  logic [OutDW-1:0] out_data_q;

  assign adv = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // Valid bits travel beside the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[Lat-2:0], s_axis_tvalid};
      out_vld_q <= vld_q[Lat-1];
    end
  end

  // Set up the rotators: half angle is the binary angle in pi/2^32 units.
  e2q_pkg::rot_t rot [NStg+1][3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rot[0][k].x = e2q_pkg::GainQ30;
      rot[0][k].y = '0;
      rot[0][k].z = CW'($signed(s_axis_tdata[k*ANGLE_BITS +: ANGLE_BITS])) <<<
                    (32 - ANGLE_BITS);
    end
  end

  // Chain of CORDIC cells.
  for (genvar g = 0; g < NStg; g++) begin : g_cordic
    e2q_cordic_cell #(.Stage(g)) u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .rot_i (rot[g]),
      .rot_o (rot[g+1])
    );
  end

  // First product stage: roll times yaw terms, pitch carried along.
  logic signed [CW-1:0] crcy_q, crsy_q, srsy_q, srcy_q, sp_q, cp_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      crcy_q <= mulq(rot[NStg][0].x, rot[NStg][2].x);
      crsy_q <= mulq(rot[NStg][0].x, rot[NStg][2].y);
      srsy_q <= mulq(rot[NStg][0].y, rot[NStg][2].y);
      srcy_q <= mulq(rot[NStg][0].y, rot[NStg][2].x);
      sp_q   <= rot[NStg][1].y;
      cp_q   <= rot[NStg][1].x;
    end
  end

  // Second product stage: eight products.
  logic signed [CW-1:0] pr_q [8];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pr_q[0] <= mulq(crcy_q, cp_q);
      pr_q[1] <= mulq(srsy_q, sp_q);
      pr_q[2] <= mulq(srcy_q, cp_q);
      pr_q[3] <= mulq(crsy_q, sp_q);
      pr_q[4] <= mulq(crcy_q, sp_q);
      pr_q[5] <= mulq(srsy_q, cp_q);
      pr_q[6] <= mulq(crsy_q, cp_q);
      pr_q[7] <= mulq(srcy_q, sp_q);
    end
  end

  // Quaternion parts.
  logic signed [CW-1:0] part_w [4];
  logic signed [CW-1:0] part_q [4];
  assign part_w[0] = pr_q[0] + pr_q[1];
  assign part_w[1] = pr_q[2] - pr_q[3];
  assign part_w[2] = pr_q[4] + pr_q[5];
  assign part_w[3] = pr_q[6] - pr_q[7];

  // Squares of the parts, then the sum. Every part stays within 32 signed bits.
  logic [RadW-1:0] sq_q [4];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      part_q <= part_w;
      for (int k = 0; k < 4; k++) begin
        sq_q[k] <= RadW'(64'($signed(part_w[k][31:0])) * 64'($signed(part_w[k][31:0])));
      end
    end
  end

  logic [RadW-1:0] rem_c  [NSqrt+1];
  logic [RadW-1:0] root_c [NSqrt+1];
  logic signed [CW-1:0] sp_c [NSqrt+1][4];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rem_c[0]  <= sq_q[0] + sq_q[1] + sq_q[2] + sq_q[3];
      root_c[0] <= '0;
      sp_c[0]   <= part_q;
    end
  end

  // Chain of square-root cells.
  for (genvar g = 0; g < NSqrt; g++) begin : g_sqrt
    e2q_sqrt_cell #(.Step(g), .RadW(RadW), .PartW(CW), .NPart(4)) u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .rem_i  (rem_c[g]),
      .root_i (root_c[g]),
      .part_i (sp_c[g]),
      .rem_o  (rem_c[g+1]),
      .root_o (root_c[g+1]),
      .part_o (sp_c[g+1])
    );
  end

  // Divider setup: magnitude scaled by one plus half the length for rounding.
  logic [DenW-1:0] den_c [NumW+1];
  logic [NumW-1:0] num_c [NumW+1][4];
  logic [DenW:0]   drem_c [NumW+1][4];
  logic [NumW-1:0] quo_c [NumW+1][4];
  logic [3:0]      neg_c [NumW+1];
  logic [DenW-1:0] len_w;
  logic [CW-1:0]   mag_w [4];
  assign len_w = DenW'(root_c[NSqrt]);
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mag_w[k] = sp_c[NSqrt][k][CW-1] ? CW'(-sp_c[NSqrt][k]) : CW'(sp_c[NSqrt][k]);
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      den_c[0] <= len_w;
      for (int k = 0; k < 4; k++) begin
        num_c[0][k]  <= NumW'((64'(mag_w[k]) << FRAC_BITS) + 64'(len_w >> 1));
        drem_c[0][k] <= '0;
        quo_c[0][k]  <= '0;
        neg_c[0][k]  <= sp_c[NSqrt][k][CW-1];
      end
    end
  end

  // Chain of divider cells, one quotient bit each.
  for (genvar g = 0; g < NumW; g++) begin : g_div
    e2q_div_cell #(.NumW(NumW), .DenW(DenW)) u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .den_i (den_c[g]),
      .num_i (num_c[g]),
      .rem_i (drem_c[g]),
      .quo_i (quo_c[g]),
      .neg_i (neg_c[g]),
      .den_o (den_c[g+1]),
      .num_o (num_c[g+1]),
      .rem_o (drem_c[g+1]),
      .quo_o (quo_c[g+1]),
      .neg_o (neg_c[g+1])
    );
  end

  // Saturate, apply the sign, and pack the output register.
  logic [NumW-1:0] one_w;
  logic [NumW-1:0] sat_w [4];
  logic [OutDW-1:0] pack_w;
  assign one_w = NumW'(1) << FRAC_BITS;
  always_comb begin
    pack_w = '0;
    for (int k = 0; k < 4; k++) begin
      if (den_c[NumW] == '0) begin
        sat_w[k] = '0;
      end else if (quo_c[NumW][k] > one_w) begin
        sat_w[k] = one_w;
      end else begin
        sat_w[k] = quo_c[NumW][k];
      end
      if (neg_c[NumW][k]) begin
        pack_w[k*OutW +: OutW] = OutW'(-sat_w[k]);
      end else begin
        pack_w[k*OutW +: OutW] = OutW'(sat_w[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= pack_w;
    end
  end

  `E2Q_ASSERT(a_out_hold, out_vld_q && !m_axis_tready |=> out_vld_q && $stable(out_data_q),
              "output transaction dropped during stall")
  `E2Q_ASSERT(a_ready_free, !out_vld_q |-> s_axis_tready, "input stalled with empty output")
  `E2Q_ASSERT(a_tail_load, adv && vld_q[Lat-1] |=> out_vld_q, "pipeline tail not loaded")
  `E2Q_ASSERT_KNOWN(a_valid_known, m_axis_tvalid, "output valid is unknown")

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the euler_to_quaternion converter.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned AngleW = 16;
  localparam int unsigned FracW  = 16;
  localparam int unsigned Stages = 16;
  localparam int unsigned PartW  = FracW + 2;
  localparam int unsigned InW    = ((3 * AngleW + 7) / 8) * 8;
  localparam int unsigned OutW   = ((4 * PartW + 7) / 8) * 8;
  localparam int unsigned NumRandom = 1950;

  typedef struct packed {
    logic [PartW-1:0] q_z;
    logic [PartW-1:0] q_y;
    logic [PartW-1:0] q_x;
    logic [PartW-1:0] q_scalar;
  } quat_t;

  // Predicts the quaternion for each angle triple and checks the results in order.
  class quat_scoreboard;
    quat_t pending_quats[$];
    int    n_errors;
    int    n_checked;

    // Floor shift of a signed value.
    function automatic longint fshift(longint v, int s);
      return v >>> s;
    endfunction

    function automatic longint mul30(longint a, longint b);
      return fshift(a * b, 30);
    endfunction

    // Half-angle sine and cosine on 30 fractional bits.
    function automatic void half_trig(logic [AngleW-1:0] raw, output longint s,
                                      output longint c);
      longint z, x, y, dx, dy, da;
      z = longint'($signed(raw)) * (longint'(1) << (32 - AngleW));
      x = longint'(e2q_pkg::GainQ30);
      y = 0;
      for (int i = 0; i < Stages && i < e2q_pkg::AtanEntries; i++) begin
        dx = fshift(y, i);
        dy = fshift(x, i);
        da = 2 * longint'(e2q_pkg::atan_turn(i));
        if (z >= 0) begin
          x -= dx; y += dy; z -= da;
        end else begin
          x += dx; y -= dy; z += da;
        end
      end
      s = y;
      c = x;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned rem, root, b;
      rem = n; root = 0; b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (rem >= root + b) begin
          rem -= root + b;
          root = (root >> 1) + b;
        end else begin
          root >>= 1;
        end
        b >>= 2;
      end
      return root;
    endfunction

    // Normalize one part, round half away from zero and saturate at one.
    function automatic logic [PartW-1:0] norm_part(longint part, longint unsigned len);
      longint unsigned mag, q;
      if (len == 0) return '0;
      mag = part < 0 ? longint'(-part) : part;
      q = ((mag << FracW) + len / 2) / len;
      if (q > (64'd1 << FracW)) q = 64'd1 << FracW;
      if (part < 0) q = -q;
      return q[PartW-1:0];
    endfunction

    function void note_angles(logic [AngleW-1:0] roll, logic [AngleW-1:0] pitch,
                              logic [AngleW-1:0] yaw);
      longint sr, cr, sp, cp, sy, cy, crcy, crsy, srsy, srcy, e0, ex, ey, ez;
      longint unsigned len;
      quat_t q;
      half_trig(roll, sr, cr);
      half_trig(pitch, sp, cp);
      half_trig(yaw, sy, cy);
      crcy = mul30(cr, cy);
      crsy = mul30(cr, sy);
      srsy = mul30(sr, sy);
      srcy = mul30(sr, cy);
      e0 = mul30(crcy, cp) + mul30(srsy, sp);
      ex = mul30(srcy, cp) - mul30(crsy, sp);
      ey = mul30(crcy, sp) + mul30(srsy, cp);
      ez = mul30(crsy, cp) - mul30(srcy, sp);
      len = int_sqrt(e0 * e0 + ex * ex + ey * ey + ez * ez);
      q.q_scalar = norm_part(e0, len);
      q.q_x = norm_part(ex, len);
      q.q_y = norm_part(ey, len);
      q.q_z = norm_part(ez, len);
      pending_quats.push_back(q);
    endfunction

    task report(string what, logic [PartW-1:0] got, logic [PartW-1:0] want);
      n_errors++;
      $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
    endtask

    task check_quat(logic [OutW-1:0] data);
      quat_t got, want;
      got = data[4*PartW-1:0];
      n_checked++;
      if (pending_quats.size() == 0) begin
        n_errors++;
        $display("unexpected result transaction");
        return;
      end
      want = pending_quats.pop_front();
      if (got.q_scalar !== want.q_scalar) report("q_scalar", got.q_scalar, want.q_scalar);
      if (got.q_x !== want.q_x) report("q_x", got.q_x, want.q_x);
      if (got.q_y !== want.q_y) report("q_y", got.q_y, want.q_y);
      if (got.q_z !== want.q_z) report("q_z", got.q_z, want.q_z);
    endtask
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [InW-1:0]  s_axis_tdata = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [OutW-1:0] m_axis_tdata;
  bit              calm = 1'b0;
  int              n_sent = 0;
  quat_scoreboard  sb = new();

  euler_to_quaternion #(
    .ANGLE_BITS(AngleW), .FRAC_BITS(FracW), .CORDIC_STAGES(Stages)
  ) i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver side: random stalls, check every result transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_quat(m_axis_tdata);
      m_axis_tready <= calm || ($urandom_range(99) >= 7);
    end
  end

  // Offer one angle triple, with an optional idle gap first.
  task automatic send_angles(logic [AngleW-1:0] roll, logic [AngleW-1:0] pitch,
                             logic [AngleW-1:0] yaw);
    while (!calm && $urandom_range(99) < 7) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= InW'({yaw, pitch, roll});
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_angles(roll, pitch, yaw);
    n_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_quats.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [AngleW-1:0] pick_angle();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(($urandom_range(7) << 13) + $urandom_range(3) - 1);
      default: return 16'($urandom);
    endcase
  endfunction

  // Main stimulus: directed corners, then random triples.
  initial begin
    logic [AngleW-1:0] corners[8];
    corners = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff, 16'h4000,
                16'hc000, 16'h2000};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < 8; i++) send_angles(corners[i], corners[(i+3)%8], corners[(i+5)%8]);
    send_angles(16'h8000, 16'h8000, 16'h8000);
    send_angles(16'h7fff, 16'h7fff, 16'h7fff);
    send_angles(16'hffff, 16'h0000, 16'h5555);
    send_angles(16'haaaa, 16'h5555, 16'hffff);
    // Let the pipeline empty completely once.
    drain();
    for (int i = 0; i < NumRandom; i++) begin
      calm = (i >= 600 && i < 900);
      if (i == 1200) drain();
      send_angles(pick_angle(), pick_angle(), 16'($urandom));
    end
    drain();
    repeat (100) @(posedge clk_i);
    $display("Sent %0d angle triples, checked %0d quaternions, with random stalls.",
             n_sent, sb.n_checked);
    if (sb.n_errors == 0 && sb.pending_quats.size() == 0) begin
      $display("PASS euler_to_quaternion");
    end else begin
      $display("FAIL euler_to_quaternion");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2ms;
    $display("FAIL euler_to_quaternion");
    $finish;
  end
endmodule
